/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the sprite draw unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define SFX_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define SFX_ASSERT_NEXT(lbl, cond, cons, msg) \
    `SFX_ASSERT(lbl, (cond) |=> (cons), msg)

`endif

/* rtl/sfx_pkg.sv */
// ----------------------------------------------------------------------------
// sfx_pkg
// Constants, command codes and shared types of the sprite draw unit.
// ----------------------------------------------------------------------------
package sfx_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;
    localparam int COL_AW = $clog2(SCREEN_WIDTH);
    localparam int ROW_AW = $clog2(SCREEN_HEIGHT);
    localparam int CNT_W  = ROW_AW + 1;
    localparam int FIFO_DEPTH = 2;

    localparam logic [2:0] CMD_CLEAR = 3'd0;
    localparam logic [2:0] CMD_DRAW  = 3'd1;
    localparam logic [2:0] CMD_DOWN  = 3'd2;
    localparam logic [2:0] CMD_LEFT  = 3'd3;
    localparam logic [2:0] CMD_RIGHT = 3'd4;
    localparam logic [2:0] CMD_READ  = 3'd5;

    localparam logic REG_EXTENDED = 1'b0;
    localparam logic REG_NO_WRAP  = 1'b1;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_DRAW,
        OP_DOWN,
        OP_LEFT,
        OP_RIGHT,
        OP_READ
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } st_t;

    typedef struct packed {
        op_t                     op;
        logic [CNT_W-1:0]        total;
        logic [ROW_AW-1:0]       base;
        logic [3:0]              lines;
        logic [COL_AW-1:0]       col;
        logic                    ext;
        logic                    last;
        logic [SCREEN_WIDTH-1:0] mask;
    } job_t;

    typedef struct packed {
        logic collision;
        logic pixel;
    } res_t;

endpackage

/* rtl/sfx_front.sv */
// ----------------------------------------------------------------------------
// sfx_front
// Accepts requests, decodes them into jobs and queues them for the engine.
// ----------------------------------------------------------------------------
module sfx_front
    import sfx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  cmd,
    input  logic [7:0]  x_pos,
    input  logic [7:0]  y_pos,
    input  logic [3:0]  row_index,
    input  logic [15:0] row_bits,
    input  logic        row_wide,
    input  logic        last_row,
    input  logic [3:0]  scroll_lines,
    input  logic        ext_mode,
    input  logic        no_wrap,
    output logic        job_valid,
    output job_t        job,
    input  logic        job_pop
);

    localparam int W  = SCREEN_WIDTH;
    localparam int HW = SCREEN_WIDTH / 2;

    job_t                     q_reg [FIFO_DEPTH];
    logic                     wptr_reg, wptr_next;
    logic                     rptr_reg, rptr_next;
    logic [1:0]               cnt_reg, cnt_next;
    job_t                     dec;
    logic [8:0]               ysum;
    logic [8:0]               yy;
    logic [15:0]              pat;
    logic [W-1:0]             mfull;
    logic [2*W-1:0]           dbl;
    logic [HW-1:0]            hfull;
    logic [W-1:0]             hdbl;
    logic [HW-1:0]            hrot;
    logic [W-1:0]             mask_c;
    logic                     do_push;
    logic                     do_pop;

    assign full      = (cnt_reg == 2'(FIFO_DEPTH));
    assign job_valid = (cnt_reg != 2'd0);
    assign job       = q_reg[rptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = job_pop && job_valid;

    always_comb
    begin
        ysum  = {1'b0, y_pos} + 9'(row_index);
        pat   = (row_wide && ext_mode) ? row_bits : {row_bits[7:0], 8'h00};
        mfull = '0;
        hfull = '0;
        for (int j = 0; j < 16; j++)
        begin
            mfull[j] = pat[15-j];
        end
        for (int j = 0; j < 8; j++)
        begin
            hfull[j] = row_bits[7-j];
        end
        dbl  = {mfull, mfull} << x_pos[COL_AW-1:0];
        hdbl = {hfull, hfull} << x_pos[COL_AW-2:0];
        hrot = hdbl[W-1:HW];
        for (int k = 0; k < HW; k++)
        begin
            mask_c[2*k]   = hrot[k];
            mask_c[2*k+1] = hrot[k];
        end
        if (no_wrap)
        begin
            yy = ysum;
        end
        else
        begin
            yy = {{(9-ROW_AW+1){1'b0}}, ysum[ROW_AW-2:0]};
        end

        dec       = '0;
        dec.ext   = ext_mode;
        dec.last  = last_row;
        dec.lines = scroll_lines;
        dec.col   = x_pos[COL_AW-1:0];
        case (cmd)
            CMD_CLEAR:
            begin
                dec.op = OP_CLEAR;
            end
            CMD_DRAW:
            begin
                dec.op = OP_DRAW;
                if (ext_mode)
                begin
                    dec.mask = dbl[2*W-1:W];
                    dec.base = ysum[ROW_AW-1:0];
                    if (!(no_wrap && ysum >= 9'(SCREEN_HEIGHT)))
                    begin
                        dec.total = CNT_W'(1);
                    end
                end
                else
                begin
                    dec.mask = mask_c;
                    dec.base = {yy[ROW_AW-2:0], 1'b0};
                    if (yy < 9'(SCREEN_HEIGHT / 2))
                    begin
                        dec.total = CNT_W'(2);
                    end
                end
            end
            CMD_DOWN:
            begin
                dec.op = OP_DOWN;
                if (scroll_lines != 4'd0)
                begin
                    dec.total = CNT_W'(SCREEN_HEIGHT);
                end
            end
            CMD_LEFT:
            begin
                dec.op    = OP_LEFT;
                dec.total = CNT_W'(SCREEN_HEIGHT);
            end
            CMD_RIGHT:
            begin
                dec.op    = OP_RIGHT;
                dec.total = CNT_W'(SCREEN_HEIGHT);
            end
            CMD_READ:
            begin
                dec.op   = OP_READ;
                dec.base = y_pos[ROW_AW-1:0];
                if (({1'b0, x_pos} < 9'(SCREEN_WIDTH)) && ({1'b0, y_pos} < 9'(SCREEN_HEIGHT)))
                begin
                    dec.total = CNT_W'(1);
                end
            end
            default:
            begin
                dec.op = OP_NONE;
            end
        endcase
    end

    always_comb
    begin
        wptr_next = do_push ? ~wptr_reg : wptr_reg;
        rptr_next = do_pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wptr_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

/* rtl/sfx_back.sv */
// ----------------------------------------------------------------------------
// sfx_back
// Carries out jobs on the frame store, one row access per cycle.
// ----------------------------------------------------------------------------
module sfx_back
    import sfx_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic job_valid,
    input  job_t job,
    output logic job_pop,
    input  logic res_ready,
    output logic res_valid,
    output res_t res
);

    localparam int W = SCREEN_WIDTH;

    logic [W-1:0]      mem [SCREEN_HEIGHT];
    logic [SCREEN_HEIGHT-1:0] vld_reg, vld_next;
    logic [W-1:0]      rdata_reg;
    logic              rvld_reg;
    st_t               st_reg, st_next;
    job_t              job_reg, job_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic [ROW_AW-1:0] paddr_reg, paddr_next;
    logic              pzero_reg, pzero_next;
    logic              hit_reg, hit_next;
    logic              pix_reg, pix_next;
    logic              seen_reg, seen_next;
    logic              issue;
    logic [ROW_AW-1:0] wr_addr;
    logic [ROW_AW-1:0] rd_addr;
    logic              wr_zero;
    logic [W-1:0]      old;
    logic [W-1:0]      wdata;
    logic              we;

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    st_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (idx_reg == job_reg.total && !pend_reg)
                begin
                    st_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        job_pop   = (st_reg == ST_IDLE) && job_valid;
        res_valid = (st_reg == ST_DONE);
        issue     = (st_reg == ST_RUN) && (idx_reg != job_reg.total);
        res.pixel = pix_reg;
        res.collision = (job_reg.op == OP_DRAW) && job_reg.last && (seen_reg || hit_reg);
    end

    always_comb
    begin
        wr_addr = idx_reg[ROW_AW-1:0];
        rd_addr = idx_reg[ROW_AW-1:0];
        wr_zero = 1'b0;
        case (job_reg.op)
            OP_DRAW:
            begin
                wr_addr = job_reg.base + idx_reg[ROW_AW-1:0];
                rd_addr = wr_addr;
            end
            OP_DOWN:
            begin
                wr_addr = ROW_AW'(SCREEN_HEIGHT - 1) - idx_reg[ROW_AW-1:0];
                rd_addr = wr_addr - ROW_AW'(job_reg.lines);
                wr_zero = wr_addr < ROW_AW'(job_reg.lines);
            end
            OP_READ:
            begin
                wr_addr = job_reg.base;
                rd_addr = job_reg.base;
            end
            default:
            begin
                wr_addr = idx_reg[ROW_AW-1:0];
                rd_addr = idx_reg[ROW_AW-1:0];
            end
        endcase
    end

    always_comb
    begin
        old   = rvld_reg ? rdata_reg : '0;
        wdata = old;
        we    = pend_reg;
        case (job_reg.op)
            OP_DRAW:
            begin
                wdata = old ^ job_reg.mask;
            end
            OP_DOWN:
            begin
                wdata = pzero_reg ? '0 : old;
            end
            OP_LEFT:
            begin
                wdata = job_reg.ext ? (old >> 4) : (old >> 2);
            end
            OP_RIGHT:
            begin
                wdata = job_reg.ext ? (old << 4) : (old << 2);
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        job_next   = job_reg;
        idx_next   = idx_reg;
        hit_next   = hit_reg;
        pix_next   = pix_reg;
        seen_next  = seen_reg;
        vld_next   = vld_reg;
        pend_next  = issue;
        paddr_next = wr_addr;
        pzero_next = wr_zero;
        if (job_pop)
        begin
            job_next = job;
            idx_next = '0;
            hit_next = 1'b0;
            pix_next = 1'b0;
            if (job.op == OP_CLEAR)
            begin
                vld_next = '0;
            end
        end
        if (issue)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end
        if (pend_reg)
        begin
            if (job_reg.op == OP_DRAW)
            begin
                hit_next = hit_reg || (|(old & job_reg.mask));
            end
            if (job_reg.op == OP_READ)
            begin
                pix_next = old[job_reg.col];
            end
        end
        if (we)
        begin
            vld_next[paddr_reg] = 1'b1;
        end
        if (st_reg == ST_DONE && res_ready && job_reg.op == OP_DRAW)
        begin
            seen_next = job_reg.last ? 1'b0 : (seen_reg || hit_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[paddr_reg] <= wdata;
        end
        rdata_reg <= mem[rd_addr];
        rvld_reg  <= vld_reg[rd_addr];
        job_reg   <= job_next;
        paddr_reg <= paddr_next;
        pzero_reg <= pzero_next;
        hit_reg   <= hit_next;
        pix_reg   <= pix_next;
        idx_reg   <= idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_IDLE;
            pend_reg <= 1'b0;
            seen_reg <= 1'b0;
            vld_reg  <= '0;
        end
        else
        begin
            st_reg   <= st_next;
            pend_reg <= pend_next;
            seen_reg <= seen_next;
            vld_reg  <= vld_next;
        end
    end

endmodule

/* rtl/sprite_framebuffer_xor_draw_unit.sv */
// ----------------------------------------------------------------------------
// sprite_framebuffer_xor_draw_unit
// Monochrome frame buffer with XOR sprite rows, scrolls and pixel reads.
//
// Channel   Direction  Handshake                  Payload
// request   in         push / full                cmd, x_pos, y_pos, row_index,
//                                                 row_bits, row_wide, last_row,
//                                                 scroll_lines
// result    out        empty / pop                collision, pixel
// config    in         psel/penable/pwrite/pready extended_mode, no_vertical_wrap
//
// The number of frame rows a request touches in the engine is 64 for scrolls,
// 2 for a classic draw, 1 for an extended draw or a read, and 0 for clear.
// While a job runs, the frame store does one row read and one row write per
// cycle.
// Two requests queue ahead of the engine and one result waits behind it.
// Reset clears the screen at once through per-row valid bits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sprite_framebuffer_xor_draw_unit
    import sfx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  cmd,
    input  logic [7:0]  x_pos,
    input  logic [7:0]  y_pos,
    input  logic [3:0]  row_index,
    input  logic [15:0] row_bits,
    input  logic        row_wide,
    input  logic        last_row,
    input  logic [3:0]  scroll_lines,
    output logic        empty,
    input  logic        pop,
    output logic        collision,
    output logic        pixel,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic ext_reg, ext_next;
    logic nowrap_reg, nowrap_next;
    logic ofull_reg, ofull_next;
    res_t ores_reg, ores_next;
    logic job_valid;
    job_t job;
    logic job_pop;
    logic res_valid;
    logic res_ready;
    res_t res;

    assign pready    = 1'b1;
    assign empty     = !ofull_reg;
    assign collision = ores_reg.collision;
    assign pixel     = ores_reg.pixel;
    assign res_ready = !ofull_reg || pop;
    assign prdata    = {31'd0, (paddr[2] == REG_NO_WRAP) ? nowrap_reg : ext_reg};

    sfx_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .cmd          (cmd),
        .x_pos        (x_pos),
        .y_pos        (y_pos),
        .row_index    (row_index),
        .row_bits     (row_bits),
        .row_wide     (row_wide),
        .last_row     (last_row),
        .scroll_lines (scroll_lines),
        .ext_mode     (ext_reg),
        .no_wrap      (nowrap_reg),
        .job_valid    (job_valid),
        .job          (job),
        .job_pop      (job_pop)
    );

    sfx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        ext_next    = ext_reg;
        nowrap_next = nowrap_reg;
        if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_EXTENDED)
            begin
                ext_next = pwdata[0];
            end
            else
            begin
                nowrap_next = pwdata[0];
            end
        end
        ofull_next = ofull_reg;
        ores_next  = ores_reg;
        if (pop && ofull_reg)
        begin
            ofull_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            ofull_next = 1'b1;
            ores_next  = res;
        end
    end

    always_ff @(posedge clk)
    begin
        ores_reg <= ores_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_reg    <= 1'b0;
            nowrap_reg <= 1'b0;
            ofull_reg  <= 1'b0;
        end
        else
        begin
            ext_reg    <= ext_next;
            nowrap_reg <= nowrap_next;
            ofull_reg  <= ofull_next;
        end
    end

    `SFX_ASSERT(a_one_field, !(ofull_reg && ores_reg.collision && ores_reg.pixel), "both result fields set")
    `SFX_ASSERT_NEXT(a_res_hold, ofull_reg && !pop, ofull_reg && $stable(ores_reg), "waiting result changed")
    `SFX_ASSERT(a_no_lost, (res_valid && !res_ready) |-> ofull_reg, "result dropped")

endmodule
